// ===== src/fmps_pkg.sv =====
// Shared constants, types and the sine table builder for the FM sine oscillator.
package fmps_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int SAMPLE_BITS     = 16;

  localparam int MOD_BITS      = 16;
  localparam int MOD_FRAC_BITS = 15;
  localparam int TUNING_BITS   = 32;
  localparam int GAIN_BITS     = 31;
  localparam int PROD_BITS     = MOD_BITS + GAIN_BITS + 1;

  localparam int QSIZE = 2 ** TABLE_ADDR_BITS;
  localparam int AMP   = 2 ** (SAMPLE_BITS - 1) - 1;

  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 32;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t REG_TUNING_WORD = cfg_index_t'(0);
  localparam cfg_index_t REG_MOD_GAIN    = cfg_index_t'(1);

  localparam logic [TUNING_BITS-1:0] TUNING_RESET = 32'd42852281;

  typedef logic [TABLE_ADDR_BITS-1:0] table_addr_t;
  typedef logic [SAMPLE_BITS-2:0]     sine_mag_t;
  typedef sine_mag_t                  sine_table_t [QSIZE];

  // (pi/2)^n / n! in Q2.30 for n = 1, 3, ..., 13.
  localparam logic [63:0] SINE_COEF [7] = '{
    64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995,
    64'd172272, 64'd3864, 64'd61
  };

  // Quarter-wave table: entry k is AMP * sin(pi/2 * (k + 1/2) / QSIZE), evaluated
  // with a Q2.30 odd polynomial of degree 13 and truncating shifts, then rounded.
  function automatic sine_table_t build_sine_table();
    sine_table_t tbl;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] acc;
    logic [63:0] s;
    logic [63:0] v;
    for (int k = 0; k < QSIZE; k++) begin
      u   = ((64'(k) << 1) + 64'd1) << (29 - TABLE_ADDR_BITS);
      u2  = (u * u) >> 30;
      acc = SINE_COEF[6];
      for (int n = 5; n >= 0; n--) begin
        acc = SINE_COEF[n] - ((acc * u2) >> 30);
      end
      s = (acc * u) >> 30;
      v = (s * 64'(AMP) + (64'd1 << 29)) >> 30;
      if (v > 64'(AMP)) begin
        v = 64'(AMP);
      end
      tbl[k] = sine_mag_t'(v);
    end
    return tbl;
  endfunction

endpackage

// ===== src/fmps_if.sv =====
// Handshake channel interfaces: modulator input, sine output and register writes.
interface fmps_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [fmps_pkg::MOD_BITS-1:0]      mod_sample;

  modport source (output valid, output mod_sample, input ready);
  modport sink   (input valid, input mod_sample, output ready);
endinterface

interface fmps_out_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [fmps_pkg::SAMPLE_BITS-1:0]   sine_sample;

  modport source (output valid, output sine_sample, input ready);
  modport sink   (input valid, input sine_sample, output ready);
endinterface

interface fmps_cfg_if;
  logic                                      valid;
  logic                                      ready;
  fmps_pkg::cfg_index_t                      reg_index;
  logic [fmps_pkg::CFG_DATA_BITS-1:0]        reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

// ===== src/fmps_mult.sv =====
// Input register and modulation product register.
module fmps_mult (
  input  logic                                    clk_i,
  input  logic                                    load_in_i,
  input  logic                                    load_prod_i,
  input  logic signed [fmps_pkg::MOD_BITS-1:0]    mod_sample_i,
  input  logic [fmps_pkg::GAIN_BITS-1:0]          mod_gain_i,
  output logic signed [fmps_pkg::PROD_BITS-1:0]   prod_o
);

  logic signed [fmps_pkg::MOD_BITS-1:0]  sample_q;
  logic signed [fmps_pkg::PROD_BITS-1:0] prod_d;
  logic signed [fmps_pkg::PROD_BITS-1:0] prod_q;

  // The gain is unsigned, so it enters the signed multiply with a zero sign bit.
  assign prod_d = sample_q * $signed({1'b0, mod_gain_i});

  always_ff @(posedge clk_i) begin
    if (load_in_i) begin
      sample_q <= mod_sample_i;
    end
    if (load_prod_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== src/fmps_phase.sv =====
// Phase accumulator and folded quarter-wave table address.
module fmps_phase (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    step_i,
  input  logic signed [fmps_pkg::PROD_BITS-1:0]   prod_i,
  input  logic [fmps_pkg::TUNING_BITS-1:0]        tuning_i,
  output fmps_pkg::table_addr_t                   addr_o,
  output logic                                    neg_o
);

  localparam int PB = fmps_pkg::PHASE_BITS;
  localparam int AB = fmps_pkg::TABLE_ADDR_BITS;

  logic [PB-1:0]         mod_inc;
  logic [PB-1:0]         inc;
  logic [PB-1:0]         phase_d;
  logic [PB-1:0]         phase_q;
  fmps_pkg::table_addr_t addr_d;
  fmps_pkg::table_addr_t addr_q;
  logic                  neg_q;

  // Arithmetic shift floors negative products; the cast truncates to the phase width, so the sum wraps.
  assign mod_inc = PB'(prod_i >>> fmps_pkg::MOD_FRAC_BITS);
  assign inc     = PB'(tuning_i) + mod_inc;
  assign phase_d = phase_q + inc;

  // Odd quadrants run the table backwards, which is the bitwise complement.
  assign addr_d = phase_d[PB-2] ? ~phase_d[PB-3 -: AB] : phase_d[PB-3 -: AB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      addr_q <= addr_d;
      neg_q  <= phase_d[PB-1];
    end
  end

  assign addr_o = addr_q;
  assign neg_o  = neg_q;

endmodule

// ===== src/fmps_rom.sv =====
// Quarter-wave sine table ROM with registered read data.
module fmps_rom (
  input  logic                  clk_i,
  input  logic                  load_i,
  input  fmps_pkg::table_addr_t addr_i,
  input  logic                  neg_i,
  output fmps_pkg::sine_mag_t   mag_o,
  output logic                  neg_o
);

  localparam fmps_pkg::sine_table_t SineRom = fmps_pkg::build_sine_table();

  fmps_pkg::sine_mag_t mag_q;
  logic                neg_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      mag_q <= SineRom[addr_i];
      neg_q <= neg_i;
    end
  end

  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule

// ===== src/fm_phase_accumulator_sine.sv =====
// Top level of the frequency-modulated direct digital synthesis sine oscillator.
//
// Usage: each item on in_i is one modulator sample in Q1.15. For every item
// the block adds tuning_word + floor(mod_sample * mod_gain / 2^15) to a
// 32-bit phase accumulator and sends the sine of the new phase on out_o as
// one Q1.15 item. Registers are written through cfg_i (index 0 is the tuning
// word, index 1 the modulation gain; other indexes are dropped) and cfg_i is
// always ready. Writes are meant to happen while no item is in flight.
// Pipeline: each accepted item passes through the input register, product
// register, phase register, ROM read register and output register.
// Throughput: one item per cycle while out_o is not stalled, set by the
// phase adder feedback loop. Reset clears the accumulator to zero, empties
// the pipeline and loads the default tuning word and a gain of zero.
// Backpressure: every stage holds its item while the next one is full and
// cannot pass its own item on, so bubbles are squeezed out and in_i stays ready
// until all five stages hold items and out_o is stalled.
module fm_phase_accumulator_sine (
  input  logic       clk_i,
  input  logic       rst_ni,
  fmps_in_if.sink    in_i,
  fmps_out_if.source out_o,
  fmps_cfg_if.sink   cfg_i
);

  // Configuration registers.
  logic [fmps_pkg::TUNING_BITS-1:0] tuning_q;
  logic [fmps_pkg::GAIN_BITS-1:0]   gain_q;

  // Stage occupancy: 0 input, 1 product, 2 phase, 3 ROM, 4 output.
  logic [4:0] valid_q;
  logic [4:0] valid_d;
  logic [4:0] load;

  logic signed [fmps_pkg::PROD_BITS-1:0] prod;
  fmps_pkg::table_addr_t                 addr;
  logic                                  addr_neg;
  fmps_pkg::sine_mag_t                   mag;
  logic                                  mag_neg;
  logic signed [fmps_pkg::SAMPLE_BITS-1:0] mag_s;
  logic signed [fmps_pkg::SAMPLE_BITS-1:0] sample_d;
  logic signed [fmps_pkg::SAMPLE_BITS-1:0] sample_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tuning_q <= fmps_pkg::TUNING_RESET;
      gain_q   <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        fmps_pkg::REG_TUNING_WORD: tuning_q <= cfg_i.reg_data[fmps_pkg::TUNING_BITS-1:0];
        fmps_pkg::REG_MOD_GAIN:    gain_q   <= cfg_i.reg_data[fmps_pkg::GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // A stage takes a new item when it is empty or its item moves on.
  always_comb begin
    load[4] = !valid_q[4] || out_o.ready;
    for (int k = 3; k >= 0; k--) begin
      load[k] = !valid_q[k] || load[k+1];
    end
    valid_d[0] = load[0] ? in_i.valid : valid_q[0];
    for (int k = 1; k < 5; k++) begin
      valid_d[k] = load[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  assign in_i.ready = load[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  fmps_mult u_mult (
    .clk_i        (clk_i),
    .load_in_i    (load[0]),
    .load_prod_i  (load[1]),
    .mod_sample_i (in_i.mod_sample),
    .mod_gain_i   (gain_q),
    .prod_o       (prod)
  );

  // The accumulator advances only when a real item enters the phase stage.
  fmps_phase u_phase (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (load[2] && valid_q[1]),
    .prod_i   (prod),
    .tuning_i (tuning_q),
    .addr_o   (addr),
    .neg_o    (addr_neg)
  );

  fmps_rom u_rom (
    .clk_i  (clk_i),
    .load_i (load[3]),
    .addr_i (addr),
    .neg_i  (addr_neg),
    .mag_o  (mag),
    .neg_o  (mag_neg)
  );

  // The second half of the turn gives the negated magnitude.
  assign mag_s    = $signed({1'b0, mag});
  assign sample_d = mag_neg ? -mag_s : mag_s;

  always_ff @(posedge clk_i) begin
    if (load[4]) begin
      sample_q <= sample_d;
    end
  end

  assign out_o.valid       = valid_q[4];
  assign out_o.sine_sample = sample_q;

endmodule

// ===== bench/fmps_tb_pkg.sv =====
// Phase tracker class that predicts and checks the sine samples of the FM oscillator.
package fmps_tb_pkg;

  typedef bit [63:0] u64_t;
  typedef logic signed [fmps_pkg::MOD_BITS-1:0]    mod_t;
  typedef logic signed [fmps_pkg::SAMPLE_BITS-1:0] sine_t;

  class sine_tracker;
    logic [fmps_pkg::TUNING_BITS-1:0] tuning;
    logic [fmps_pkg::GAIN_BITS-1:0]   gain;
    logic [fmps_pkg::PHASE_BITS-1:0]  phase;
    int unsigned                      quarter_wave [fmps_pkg::QSIZE];
    sine_t                            due_sines [$];
    int unsigned                      failures;

    // The table is rebuilt here with the same Q2.30 Taylor series and truncating shifts.
    function new();
      u64_t taylor [7];
      u64_t x;
      u64_t x2;
      u64_t poly;
      u64_t mag;
      taylor = '{64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995,
                 64'd172272, 64'd3864, 64'd61};
      for (int k = 0; k < fmps_pkg::QSIZE; k++) begin
        x    = u64_t'(2 * k + 1) << (29 - fmps_pkg::TABLE_ADDR_BITS);
        x2   = (x * x) >> 30;
        poly = taylor[6];
        for (int n = 5; n >= 0; n--) begin
          poly = taylor[n] - ((poly * x2) >> 30);
        end
        mag = (((poly * x) >> 30) * u64_t'(fmps_pkg::AMP) + (u64_t'(1) << 29)) >> 30;
        if (mag > u64_t'(fmps_pkg::AMP)) begin
          mag = u64_t'(fmps_pkg::AMP);
        end
        quarter_wave[k] = mag[31:0];
      end
      tuning   = fmps_pkg::TUNING_RESET;
      gain     = '0;
      phase    = '0;
      failures = 0;
    endfunction

    function void write_register(fmps_pkg::cfg_index_t idx,
                                 logic [fmps_pkg::CFG_DATA_BITS-1:0] data);
      case (idx)
        fmps_pkg::REG_TUNING_WORD: begin
          tuning = data[fmps_pkg::TUNING_BITS-1:0];
        end
        fmps_pkg::REG_MOD_GAIN: begin
          gain = data[fmps_pkg::GAIN_BITS-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function void note_modulation(mod_t mod);
      longint                shifted;
      longint                prod;
      logic [1:0]            quad;
      fmps_pkg::table_addr_t addr;
      sine_t                 level;
      prod    = longint'(mod) * longint'({1'b0, gain});
      shifted = prod >>> fmps_pkg::MOD_FRAC_BITS;
      phase   = phase + tuning + shifted[fmps_pkg::PHASE_BITS-1:0];
      quad    = phase[fmps_pkg::PHASE_BITS-1 -: 2];
      addr    = phase[fmps_pkg::PHASE_BITS-3 -: fmps_pkg::TABLE_ADDR_BITS];
      // Odd quadrants read the table backward.
      if (quad[0]) begin
        addr = ~addr;
      end
      level = sine_t'(quarter_wave[addr]);
      if (quad[1]) begin
        level = -level;
      end
      due_sines.push_back(level);
    endfunction

    function void check_sine(sine_t got, time now);
      sine_t want;
      if (due_sines.size() == 0) begin
        failures++;
        $display("%0d ns: sine sample mismatch, expected none, got %0d", now, got);
      end else begin
        want = due_sines.pop_front();
        if (got !== want) begin
          failures++;
          $display("%0d ns: sine sample mismatch, expected %0d, got %0d", now, want, got);
        end
      end
    endfunction

    function int unsigned pending();
      return due_sines.size();
    endfunction

    function void flag_leftovers(time now);
      foreach (due_sines[i]) begin
        failures++;
        $display("%0d ns: sine sample mismatch, expected %0d, got none", now, due_sines[i]);
      end
    endfunction
  endclass

endpackage

// ===== bench/fm_phase_accumulator_sine_tb.sv =====
// Testbench for the FM sine oscillator: random handshakes checked against a phase tracker.
module fm_phase_accumulator_sine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Nothing is accepted for this many cycles only if the block has hung. The worst
  // correct quiet stretch is the longest receiver stall plus the pipeline.
  localparam int IDLE_LIMIT      = 400;
  localparam int DRAIN_CYCLES    = 10;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 117;

  localparam fmps_tb_pkg::mod_t MOD_MIN     = {1'b1, {(fmps_pkg::MOD_BITS-1){1'b0}}};
  localparam fmps_tb_pkg::mod_t MOD_MAX     = {1'b0, {(fmps_pkg::MOD_BITS-1){1'b1}}};
  localparam fmps_tb_pkg::mod_t MOD_ZERO    = '0;
  localparam fmps_tb_pkg::mod_t MOD_ONE     = fmps_tb_pkg::mod_t'(1);
  localparam fmps_tb_pkg::mod_t MOD_NEG_ONE = '1;

  // Receiver behaviors: always ready, coin flip, long on/off stretches, mostly ready.
  typedef enum int {RX_OPEN, RX_COIN, RX_BURSTY, RX_MOSTLY} rx_mode_e;

  logic clk_i;
  logic rst_ni;

  fmps_in_if  in_ch ();
  fmps_out_if out_ch ();
  fmps_cfg_if cfg_ch ();

  fmps_tb_pkg::sine_tracker   tracker;
  fmps_tb_pkg::mod_t          mod_stim [$];
  int unsigned                idle_cycles = 0;
  rx_mode_e                   rx_mode     = RX_OPEN;
  int unsigned                rx_cycle    = 0;
  int unsigned                rx_hold     = 0;
  logic                       rx_level    = 1'b0;

  fm_phase_accumulator_sine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // One register write. The valid stays up when another write follows directly, so
  // that it is never lowered and raised again within one time step.
  task automatic write_register(input fmps_pkg::cfg_index_t idx,
                                input logic [fmps_pkg::CFG_DATA_BITS-1:0] data,
                                input bit last_write);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.reg_data  <= data;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    tracker.write_register(idx, data);
    if (last_write) begin
      cfg_ch.valid <= 1'b0;
    end
  endtask

  task automatic set_oscillator(input logic [fmps_pkg::CFG_DATA_BITS-1:0] tuning_data,
                                input logic [fmps_pkg::CFG_DATA_BITS-1:0] gain_data);
    write_register(fmps_pkg::REG_TUNING_WORD, tuning_data, 1'b0);
    write_register(fmps_pkg::REG_MOD_GAIN, gain_data, 1'b1);
  endtask

  // Sends every queued modulator item in bursts of random length. A steady run has
  // no gaps at all. Afterwards it waits until every sine sample has come back, so
  // the block is idle when the next register write comes.
  task automatic play_modulation(input bit steady);
    int unsigned burst_left;
    int unsigned gap;
    burst_left = 0;
    while (mod_stim.size() > 0) begin
      if (burst_left == 0) begin
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst_left = $urandom_range(1, 40);
      end
      in_ch.valid      <= 1'b1;
      in_ch.mod_sample <= mod_stim[0];
      do @(posedge clk_i); while (in_ch.ready !== 1'b1);
      tracker.note_modulation(mod_stim.pop_front());
      burst_left--;
    end
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  // Random modulator content: smooth ramps as a real audio modulator would give,
  // full-scale and near-zero values, and plain noise.
  function automatic void queue_random_modulation(input int unsigned count);
    fmps_tb_pkg::mod_t level;
    fmps_tb_pkg::mod_t slope;
    int unsigned       run;
    while (count > 0) begin
      case ($urandom_range(0, 3))
        0: begin
          level = fmps_tb_pkg::mod_t'($urandom);
          slope = fmps_tb_pkg::mod_t'(int'($urandom_range(0, 2047)) - 1024);
          run   = $urandom_range(4, 24);
          for (int i = 0; i < run && count > 0; i++) begin
            mod_stim.push_back(level);
            level += slope;
            count--;
          end
        end
        1: begin
          case ($urandom_range(0, 4))
            0:       mod_stim.push_back(MOD_MIN);
            1:       mod_stim.push_back(MOD_MAX);
            2:       mod_stim.push_back(MOD_NEG_ONE);
            3:       mod_stim.push_back(MOD_ONE);
            default: mod_stim.push_back(MOD_ZERO);
          endcase
          count--;
        end
        default: begin
          mod_stim.push_back(fmps_tb_pkg::mod_t'($urandom));
          count--;
        end
      endcase
    end
  endfunction

  function automatic logic [fmps_pkg::CFG_DATA_BITS-1:0] pick_tuning();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(1, 1 << 22);  // slow sweep through the table
      3:       return fmps_pkg::TUNING_RESET;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [fmps_pkg::CFG_DATA_BITS-1:0] pick_gain();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return 32'h7FFF_FFFF;
      2:       return $urandom_range(0, 1 << 20);
      default: return $urandom;  // the top bit is dropped by the block
    endcase
  endfunction

  // The receiver switches among its behaviors at random intervals, so stalls
  // land on every stage of the pipeline and there are stretches with none.
  always @(posedge clk_i) begin
    if (rx_cycle == 0) begin
      rx_mode  = rx_mode_e'($urandom_range(0, 3));
      rx_cycle = $urandom_range(20, 120);
    end
    rx_cycle--;
    case (rx_mode)
      RX_OPEN: begin
        out_ch.ready <= 1'b1;
      end
      RX_COIN: begin
        out_ch.ready <= 1'($urandom_range(0, 1));
      end
      RX_BURSTY: begin
        if (rx_hold == 0) begin
          rx_level = !rx_level;
          rx_hold  = rx_level ? $urandom_range(1, 12) : $urandom_range(1, 20);
        end
        rx_hold--;
        out_ch.ready <= rx_level;
      end
      default: begin
        out_ch.ready <= ($urandom_range(0, 3) != 0);
      end
    endcase
  end

  // Result checking and the hang watchdog. Inputs are noted by the driver at the
  // edge that accepts them, so the predictor never lags a register write.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        tracker.check_sine(out_ch.sine_sample, $time);
      end
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
          (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
        idle_cycles = 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cycles++;
      end
    end
  end

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.mod_sample = '0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = fmps_pkg::REG_TUNING_WORD;
    cfg_ch.reg_data  = '0;
    rst_ni           = 1'b0;
    tracker          = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: the default tuning word and no modulation, so the modulator
    // extremes must not move the pitch.
    mod_stim = '{MOD_ZERO, MOD_MAX, MOD_MIN};
    play_modulation(1'b1);

    // Zero base increment and a gain of one. A sample of -1 must floor to a step
    // of -1.
    set_oscillator('0, 32'd1);
    mod_stim = '{MOD_NEG_ONE, MOD_ONE, MOD_MIN, MOD_MAX};
    play_modulation(1'b0);

    // Largest tuning word and gain: the increment overflows and must wrap.
    set_oscillator('1, 32'h7FFF_FFFF);
    mod_stim = '{MOD_MAX, MOD_MIN, MOD_NEG_ONE, MOD_ZERO, MOD_ONE};
    play_modulation(1'b1);

    // A write to an index past the register list must change nothing, and the top
    // data bit of the gain must be dropped. Quarter-turn steps then move the phase one
    // quadrant at a time.
    write_register(fmps_pkg::cfg_index_t'($urandom_range(2, 255)), $urandom, 1'b0);
    write_register(fmps_pkg::REG_MOD_GAIN, 32'hFFFF_FFFF, 1'b0);
    write_register(fmps_pkg::REG_TUNING_WORD, 32'h4000_0000, 1'b1);
    mod_stim = '{MOD_ZERO, MOD_ZERO, MOD_ZERO, MOD_ZERO, MOD_MIN};
    play_modulation(1'b0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_oscillator(pick_tuning(), pick_gain());
      queue_random_modulation(ITEMS_PER_PHASE);
      play_modulation($urandom_range(0, 3) == 0);
    end

    // Anything that shows up now was never asked for.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    tracker.flag_leftovers($time);
    if (tracker.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
